@@ hdl/lpg_pkg.sv @@
// Shared constants and types for the Lissajous point generator.
`default_nettype none
package lpg_pkg;

    localparam int MULT_LIMIT = 100;
    localparam int MIN_POINTS = 2;

    localparam logic [12:0] SIN_C    = 13'd4640;
    localparam logic [15:0] SIN_B    = 16'd42047;
    localparam logic [16:0] SIN_A    = 17'd102944;
    localparam logic [15:0] ONE_Q14  = 16'd16384;

    localparam logic [2:0] REG_X_MULT      = 3'd0;
    localparam logic [2:0] REG_Y_MULT      = 3'd1;
    localparam logic [2:0] REG_Z_MULT      = 3'd2;
    localparam logic [2:0] REG_POINT_COUNT = 3'd3;
    localparam logic [2:0] REG_PHASE_STEP  = 3'd4;

    typedef struct packed {
        logic full;
        logic empty;
    } lpg_q_status_t;

endpackage
`default_nettype wire

@@ hdl/lpg_front.sv @@
// Front end: takes stream items, runs the sweep state and queues points.
`default_nettype none
module lpg_front #(
    parameter int PHASE_BITS       = 24,
    parameter int MAX_POINTS_LIMIT = 1000
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic                   restart,
    input  wire logic [9:0]             point_count,
    input  wire logic [23:0]            phase_step,
    input  wire lpg_pkg::lpg_q_status_t q_status,
    output logic                        push,
    output logic [PHASE_BITS-1:0]       push_phase,
    output logic [9:0]                  push_index,
    output logic                        push_last
);
    import lpg_pkg::*;

    localparam int CLW = $clog2(MAX_POINTS_LIMIT + 1);
    localparam int NW  = (CLW > 10) ? CLW : 10;

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [9:0]            point_counter_reg, point_counter_next;
    logic                  sweep_active_reg, sweep_active_next;

    logic                  accept;
    logic                  active;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [9:0]            cur_count;
    logic [NW-1:0]         pc_ext;
    logic [NW-1:0]         n_eff;
    logic                  last;
    logic [PHASE_BITS-1:0] step_scaled;

    generate
        if (PHASE_BITS == 24) begin : g_step_eq
            assign step_scaled = phase_step;
        end
        else if (PHASE_BITS > 24) begin : g_step_up
            assign step_scaled = {phase_step, {(PHASE_BITS-24){1'b0}}};
        end
        else begin : g_step_dn
            assign step_scaled = phase_step[23 -: PHASE_BITS];
        end
    endgenerate

    always_comb
    begin
        s_tready  = ~q_status.full;
        accept    = s_tvalid & s_tready;
        active    = restart | sweep_active_reg;
        cur_phase = restart ? '0 : phase_acc_reg;
        cur_count = restart ? '0 : point_counter_reg;

        pc_ext = NW'(point_count);
        if (pc_ext < NW'(MIN_POINTS))
        begin
            n_eff = NW'(MIN_POINTS);
        end
        else if (pc_ext > NW'(MAX_POINTS_LIMIT))
        begin
            n_eff = NW'(MAX_POINTS_LIMIT);
        end
        else
        begin
            n_eff = pc_ext;
        end
        last = NW'(cur_count) >= (n_eff - NW'(1));

        push       = accept & active;
        push_phase = cur_phase;
        push_index = cur_count;
        push_last  = last;

        phase_acc_next     = phase_acc_reg;
        point_counter_next = point_counter_reg;
        sweep_active_next  = sweep_active_reg;
        if (push)
        begin
            if (last)
            begin
                phase_acc_next     = cur_phase;
                point_counter_next = cur_count;
                sweep_active_next  = 1'b0;
            end
            else
            begin
                phase_acc_next     = cur_phase + step_scaled;
                point_counter_next = cur_count + 10'd1;
                sweep_active_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg     <= '0;
            point_counter_reg <= '0;
            sweep_active_reg  <= 1'b0;
        end
        else
        begin
            phase_acc_reg     <= phase_acc_next;
            point_counter_reg <= point_counter_next;
            sweep_active_reg  <= sweep_active_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/lpg_queue.sv @@
// Short queue between front end and sine pipeline.
`default_nettype none
module lpg_queue #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output lpg_pkg::lpg_q_status_t  status
);
    import lpg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        status.full  = (count_reg == CW'(DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push & ~status.full;
        do_pop       = pop & ~status.empty;
        pop_data     = mem[rd_ptr_reg];
        count_next   = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/lpg_sine.sv @@
// One sine lane: five-stage pipeline, angle multiply then polynomial evaluation.
`default_nettype none
module lpg_sine #(
    parameter int PHASE_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [PHASE_BITS-1:0] phase,
    input  wire logic [7:0]            mult,
    input  wire logic                  cos_sel,
    output logic [15:0]                result
);
    import lpg_pkg::*;

    localparam int RB = PHASE_BITS - 2;

    logic signed [PHASE_BITS+8:0] prod;
    logic [PHASE_BITS-1:0]        quarter;
    logic [PHASE_BITS-1:0]        angle_next;
    logic [PHASE_BITS-1:0]        angle_reg;

    logic [15:0]  u;
    logic [16:0]  x_b;
    logic [33:0]  sq;
    logic [16:0]  x_b_reg, x2_b_reg;
    logic [1:0]   q_b_reg;

    logic [29:0]  p1;
    logic [13:0]  t1_c_reg;
    logic [16:0]  x_c_reg, x2_c_reg;
    logic [1:0]   q_c_reg;

    logic [15:0]  diff_b;
    logic [32:0]  p2;
    logic [16:0]  t2_d_reg, x_d_reg;
    logic [1:0]   q_d_reg;

    logic [16:0]  diff_a;
    logic [33:0]  p3;
    logic [15:0]  m_raw, m_sat;
    logic [15:0]  result_reg;

    generate
        if (RB >= 16) begin : g_u_dn
            assign u = angle_reg[RB-1 -: 16];
        end
        else begin : g_u_up
            assign u = {angle_reg[RB-1:0], {(16-RB){1'b0}}};
        end
    endgenerate

    always_comb
    begin
        quarter    = {2'b01, {RB{1'b0}}};
        prod       = $signed(mult) * $signed({1'b0, phase});
        angle_next = prod[PHASE_BITS-1:0] + (cos_sel ? quarter : '0);

        x_b = angle_reg[PHASE_BITS-2] ? (17'd65536 - {1'b0, u}) : {1'b0, u};
        sq  = x_b * x_b + 34'd32768;

        p1 = x2_b_reg * SIN_C;

        diff_b = SIN_B - {2'b00, t1_c_reg};
        p2     = x2_c_reg * diff_b;

        diff_a = SIN_A - t2_d_reg;
        p3     = x_d_reg * diff_a + 34'd131072;
        m_raw  = p3[33:18];
        m_sat  = (m_raw > ONE_Q14) ? ONE_Q14 : m_raw;

        result = result_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg  <= angle_next;

            x_b_reg    <= x_b;
            x2_b_reg   <= sq[32:16];
            q_b_reg    <= angle_reg[PHASE_BITS-1 -: 2];

            t1_c_reg   <= p1[29:16];
            x_c_reg    <= x_b_reg;
            x2_c_reg   <= x2_b_reg;
            q_c_reg    <= q_b_reg;

            t2_d_reg   <= p2[32:16];
            x_d_reg    <= x_c_reg;
            q_d_reg    <= q_c_reg;

            result_reg <= q_d_reg[1] ? (16'd0 - m_sat) : m_sat;
        end
    end

endmodule
`default_nettype wire

@@ hdl/lpg_back.sv @@
// Back end: three sine lanes, pipeline valid/sideband and output register.
`default_nettype none
module lpg_back #(
    parameter int PHASE_BITS = 24
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lpg_pkg::lpg_q_status_t q_status,
    input  wire logic [PHASE_BITS+10:0] q_data,
    output logic                        pop,
    input  wire logic [7:0]             x_mult,
    input  wire logic [7:0]             y_mult,
    input  wire logic [7:0]             z_mult,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [63:0]                 m_tdata,
    output logic                        m_tlast
);
    import lpg_pkg::*;

    localparam int STAGES = 5;

    logic                  en;
    logic [PHASE_BITS-1:0] q_phase;
    logic [9:0]            q_index;
    logic                  q_last;

    logic [STAGES-1:0] valid_reg;
    logic [9:0]        index_reg [STAGES];
    logic              last_reg  [STAGES];

    logic [15:0] x_val, y_val, z_val;

    always_comb
    begin
        en       = ~valid_reg[STAGES-1] | m_tready;
        pop      = en & ~q_status.empty;
        q_phase  = q_data[PHASE_BITS-1:0];
        q_index  = q_data[PHASE_BITS+9:PHASE_BITS];
        q_last   = q_data[PHASE_BITS+10];
        m_tvalid = valid_reg[STAGES-1];
        m_tlast  = last_reg[STAGES-1];
        m_tdata  = {6'd0, index_reg[STAGES-1], z_val, y_val, x_val};
    end

    lpg_sine #(.PHASE_BITS(PHASE_BITS)) u_sine_x (
        .clk     (clk),
        .en      (en),
        .phase   (q_phase),
        .mult    (x_mult),
        .cos_sel (1'b0),
        .result  (x_val)
    );

    lpg_sine #(.PHASE_BITS(PHASE_BITS)) u_sine_y (
        .clk     (clk),
        .en      (en),
        .phase   (q_phase),
        .mult    (y_mult),
        .cos_sel (1'b1),
        .result  (y_val)
    );

    lpg_sine #(.PHASE_BITS(PHASE_BITS)) u_sine_z (
        .clk     (clk),
        .en      (en),
        .phase   (q_phase),
        .mult    (z_mult),
        .cos_sel (1'b0),
        .result  (z_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            index_reg[0] <= q_index;
            last_reg[0]  <= q_last;
            for (int i = 1; i < STAGES; i++)
            begin
                index_reg[i] <= index_reg[i-1];
                last_reg[i]  <= last_reg[i-1];
            end
        end
    end

endmodule
`default_nettype wire

@@ hdl/lissajous_point_generator.sv @@
// Top level: APB register block, front end, queue and sine back end.
//
//  channel  dir  handshake                   payload
//  s_       in   s_tvalid / s_tready         s_tdata[0] restart
//  m_       out  m_tvalid / m_tready         m_tdata x,y,z,point_index; m_tlast
//  apb      in   psel & penable, pready=1    registers at 4*index
//
// One item accepted per clock while the queue is not full. An emitted point
// passes through the 4-entry queue, then the sine lanes, whose last stage is
// the output register. Reset clears the sweep state, the queue and all pipeline
// valid bits; registers return to defaults. A low m_tready with m_tvalid high
// freezes the lanes; the queue absorbs items until full, then s_tready drops.
`default_nettype none
module lissajous_point_generator #(
    parameter int PHASE_BITS       = 24,
    parameter int MAX_POINTS_LIMIT = 1000
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [15:0] x_value, [31:16] y_value,
                                        // [47:32] z_value, [57:48] point_index
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lpg_pkg::*;

    localparam int QW = PHASE_BITS + 11;

    logic [7:0]  x_mult_reg, y_mult_reg, z_mult_reg;
    logic [9:0]  point_count_reg;
    logic [23:0] phase_step_reg;

    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [7:0]  mult_clamped;

    lpg_q_status_t         q_status;
    logic                  push, pop, push_last;
    logic [PHASE_BITS-1:0] push_phase;
    logic [9:0]            push_index;
    logic [QW-1:0]         q_data;

    always_comb
    begin
        pready  = 1'b1;
        wr_en   = psel & penable & pwrite & pready;
        reg_idx = paddr[4:2];

        if ($signed(pwdata[7:0]) < $signed(-8'sd100))
        begin
            mult_clamped = 8'(-MULT_LIMIT);
        end
        else if ($signed(pwdata[7:0]) > $signed(8'sd100))
        begin
            mult_clamped = 8'(MULT_LIMIT);
        end
        else
        begin
            mult_clamped = pwdata[7:0];
        end

        unique case (reg_idx)
            REG_X_MULT:      prdata = {{24{x_mult_reg[7]}}, x_mult_reg};
            REG_Y_MULT:      prdata = {{24{y_mult_reg[7]}}, y_mult_reg};
            REG_Z_MULT:      prdata = {{24{z_mult_reg[7]}}, z_mult_reg};
            REG_POINT_COUNT: prdata = {22'd0, point_count_reg};
            REG_PHASE_STEP:  prdata = {8'd0, phase_step_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_mult_reg      <= 8'd3;
            y_mult_reg      <= 8'd5;
            z_mult_reg      <= 8'd7;
            point_count_reg <= 10'd100;
            phase_step_reg  <= 24'd167772;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_X_MULT:      x_mult_reg      <= mult_clamped;
                REG_Y_MULT:      y_mult_reg      <= mult_clamped;
                REG_Z_MULT:      z_mult_reg      <= mult_clamped;
                REG_POINT_COUNT: point_count_reg <= pwdata[9:0];
                REG_PHASE_STEP:  phase_step_reg  <= pwdata[23:0];
                default:         ;
            endcase
        end
    end

    lpg_front #(
        .PHASE_BITS       (PHASE_BITS),
        .MAX_POINTS_LIMIT (MAX_POINTS_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .restart     (s_tdata[0]),
        .point_count (point_count_reg),
        .phase_step  (phase_step_reg),
        .q_status    (q_status),
        .push        (push),
        .push_phase  (push_phase),
        .push_index  (push_index),
        .push_last   (push_last)
    );

    lpg_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_last, push_index, push_phase}),
        .pop       (pop),
        .pop_data  (q_data),
        .status    (q_status)
    );

    lpg_back #(.PHASE_BITS(PHASE_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_data   (q_data),
        .pop      (pop),
        .x_mult   (x_mult_reg),
        .y_mult   (y_mult_reg),
        .z_mult   (z_mult_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

@@ tb/sv/lissajous_point_generator_tb.sv @@
// Self-checking testbench for the Lissajous point generator: APB setup, stream in, points out.
`timescale 1ns / 1ps
module lissajous_point_generator_tb;

    localparam int               DRAIN_CYCLES  = 16;
    localparam int               CYCLE_LIMIT   = 1000000;
    localparam int               TARGET_ITEMS  = 1900;
    localparam int               MULT_SAT      = 100;
    localparam int               COUNT_MIN     = 2;
    localparam int               COUNT_MAX     = 1000;
    localparam longint unsigned  POLY_A        = 102944;
    localparam longint unsigned  POLY_B        = 42047;
    localparam longint unsigned  POLY_C        = 4640;
    localparam longint unsigned  Q14_ONE       = 16384;
    localparam logic [23:0]      QUARTER_TURN  = 24'h400000;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic signed [15:0] z_value;
        logic [9:0]         point_index;
        logic               last_point;
    } point_t;

    typedef struct {
        bit          reg_write;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        bit          restart;
        bit          typed;
        point_t      pt;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // [15:0] x, [31:16] y, [47:32] z, [57:48] point_index
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // model of the sweep and its register copies
    int          mult_x, mult_y, mult_z;
    logic [9:0]  count_reg;
    logic [23:0] step_reg;
    logic [23:0] phase_acc;
    logic [9:0]  point_ctr;
    bit          sweep_on;

    point_t      pending_points[$];
    int          items_sent = 0;
    int          mismatches = 0;
    int          cycles = 0;
    bit          steady = 1'b0;

    lissajous_point_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int clamp_mult(logic [31:0] v);
        int k;
        k = int'($signed(v[7:0]));
        if (k < -MULT_SAT)
            k = -MULT_SAT;
        if (k > MULT_SAT)
            k = MULT_SAT;
        return k;
    endfunction

    function automatic int effective_count();
        int n;
        n = int'(count_reg);
        if (n < COUNT_MIN)
            n = COUNT_MIN;
        if (n > COUNT_MAX)
            n = COUNT_MAX;
        return n;
    endfunction

    // polynomial sine of a 24-bit turn fraction, Q1.14
    function automatic logic signed [15:0] sine_q14(logic [23:0] ang);
        logic [1:0]      quad;
        longint unsigned u, xv, x2, t1, t2, m;
        quad = ang[23:22];
        u    = ang[21:6];
        xv   = quad[0] ? 65536 - u : u;
        x2   = (xv * xv + 32768) >> 16;
        t1   = (x2 * POLY_C) >> 16;
        t2   = (x2 * (POLY_B - t1)) >> 16;
        m    = (xv * (POLY_A - t2) + 131072) >> 18;
        if (m > Q14_ONE)
            m = Q14_ONE;
        return quad[1] ? -16'(m) : 16'(m);
    endfunction

    function automatic logic [23:0] turn_angle(int k, logic [23:0] ph);
        longint p;
        p = longint'(k) * longint'(ph);
        return p[23:0];
    endfunction

    task automatic predict_point(input bit restart, output bit emitted, output point_t pt);
        bit lst;
        emitted = 1'b0;
        pt      = '0;
        if (restart)
        begin
            phase_acc = '0;
            point_ctr = '0;
            sweep_on  = 1'b1;
        end
        if (sweep_on)
        begin
            lst            = int'(point_ctr) >= effective_count() - 1;
            pt.x_value     = sine_q14(turn_angle(mult_x, phase_acc));
            pt.y_value     = sine_q14(turn_angle(mult_y, phase_acc) + QUARTER_TURN);
            pt.z_value     = sine_q14(turn_angle(mult_z, phase_acc));
            pt.point_index = point_ctr;
            pt.last_point  = lst;
            emitted        = 1'b1;
            if (lst)
                sweep_on = 1'b0;
            else
            begin
                point_ctr = point_ctr + 10'd1;
                phase_acc = phase_acc + step_reg;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < 40)
            $display("MISMATCH %s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycles);
        mismatches++;
    endtask

    task automatic check_point();
        point_t want;
        if (pending_points.size() == 0)
        begin
            report_mismatch("point with none pending", m_tdata, 64'd0);
            return;
        end
        want = pending_points.pop_front();
        if (m_tdata[15:0] !== want.x_value)
            report_mismatch("x_value", m_tdata[15:0], want.x_value);
        if (m_tdata[31:16] !== want.y_value)
            report_mismatch("y_value", m_tdata[31:16], want.y_value);
        if (m_tdata[47:32] !== want.z_value)
            report_mismatch("z_value", m_tdata[47:32], want.z_value);
        if (m_tdata[57:48] !== want.point_index)
            report_mismatch("point_index", m_tdata[57:48], want.point_index);
        if (m_tdata[63:58] !== 6'd0)
            report_mismatch("tdata padding", m_tdata[63:58], 64'd0);
        if (m_tlast !== want.last_point)
            report_mismatch("last_point", m_tlast, want.last_point);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_point();
    end

    // sink back-pressure
    initial
    begin
        int hold;
        int r;
        bit rdy;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (steady || r < 60)
                begin
                    rdy  = 1'b1;
                    hold = $urandom_range(0, 15);
                end
                else if (r < 94)
                begin
                    rdy  = 1'b0;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    rdy  = 1'b0;
                    hold = $urandom_range(10, 40);
                end
                m_tready <= rdy;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_mult();
        logic [31:0] v;
        int          r, k;
        v = $urandom();
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            k       = int'($urandom_range(0, 200)) - 100;
            v[7:0]  = k[7:0];
        end
        else if (r < 85)
        begin
            k       = ($urandom_range(0, 1) != 0) ? MULT_SAT : -MULT_SAT;
            v[7:0]  = k[7:0];
        end
        return v;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            lpg_pkg::REG_X_MULT:      mult_x    = clamp_mult(v);
            lpg_pkg::REG_Y_MULT:      mult_y    = clamp_mult(v);
            lpg_pkg::REG_Z_MULT:      mult_z    = clamp_mult(v);
            lpg_pkg::REG_POINT_COUNT: count_reg = v[9:0];
            lpg_pkg::REG_PHASE_STEP:  step_reg  = v[23:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input bit restart, input bit typed, input point_t typed_pt);
        int     gap;
        bit     emitted;
        point_t pt;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        predict_point(restart, emitted, pt);
        if (typed)
            pt = typed_pt;
        if (typed || emitted)
        begin
            pending_points.push_back(pt);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic stim_row_t tick(bit r);
        stim_row_t row;
        row         = '{default: '0};
        row.restart = r;
        return row;
    endfunction

    function automatic stim_row_t tick_pt(bit r, int xv, int yv, int zv, int idx, bit lst);
        stim_row_t row;
        row         = tick(r);
        row.typed   = 1'b1;
        row.pt      = '{16'(xv), 16'(yv), 16'(zv), 10'(idx), lst};
        return row;
    endfunction

    function automatic stim_row_t cfg(logic [2:0] idx, logic [31:0] v);
        stim_row_t row;
        row           = '{default: '0};
        row.reg_write = 1'b1;
        row.reg_idx   = idx;
        row.reg_val   = v;
        return row;
    endfunction

    initial
    begin
        stim_row_t   rows[$];
        point_t      none;
        bit          restart;
        int          n_items;
        int          r;
        int          n;
        logic [31:0] v;

        none      = '0;
        mult_x    = 3;
        mult_y    = 5;
        mult_z    = 7;
        count_reg = 10'd100;
        step_reg  = 24'd167772;
        phase_acc = '0;
        point_ctr = '0;
        sweep_on  = 1'b0;

        // idle tick, then a sweep at reset settings
        rows.push_back(tick(1'b0));
        rows.push_back(tick_pt(1'b1, 0, 16384, 0, 0, 1'b0));
        rows.push_back(tick(1'b0));
        rows.push_back(tick(1'b0));
        // quarter-turn steps with unit multipliers hit the axis extremes
        rows.push_back(cfg(lpg_pkg::REG_X_MULT, 32'd1));
        rows.push_back(cfg(lpg_pkg::REG_Y_MULT, 32'd1));
        rows.push_back(cfg(lpg_pkg::REG_Z_MULT, 32'd1));
        rows.push_back(cfg(lpg_pkg::REG_PHASE_STEP, 32'h0040_0000));
        rows.push_back(cfg(lpg_pkg::REG_POINT_COUNT, 32'd4));
        rows.push_back(tick_pt(1'b1, 0, 16384, 0, 0, 1'b0));
        rows.push_back(tick_pt(1'b0, 16384, 0, 16384, 1, 1'b0));
        rows.push_back(tick_pt(1'b0, 0, -16384, 0, 2, 1'b0));
        rows.push_back(tick_pt(1'b0, -16384, 0, -16384, 3, 1'b1));
        rows.push_back(tick(1'b0));
        // count below minimum, zero step
        rows.push_back(cfg(lpg_pkg::REG_POINT_COUNT, 32'd0));
        rows.push_back(cfg(lpg_pkg::REG_PHASE_STEP, 32'd0));
        rows.push_back(tick_pt(1'b1, 0, 16384, 0, 0, 1'b0));
        rows.push_back(tick_pt(1'b0, 0, 16384, 0, 1, 1'b1));
        rows.push_back(tick(1'b0));
        // saturating multipliers, count above maximum, largest step
        rows.push_back(cfg(lpg_pkg::REG_X_MULT, 32'h0000_0080));
        rows.push_back(cfg(lpg_pkg::REG_Y_MULT, 32'hFFFF_FF7F));
        rows.push_back(cfg(lpg_pkg::REG_Z_MULT, 32'h0000_009C));
        rows.push_back(cfg(lpg_pkg::REG_POINT_COUNT, 32'h0000_03FF));
        rows.push_back(cfg(lpg_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF));
        rows.push_back(tick_pt(1'b1, 0, 16384, 0, 0, 1'b0));
        rows.push_back(tick(1'b0));
        rows.push_back(tick(1'b0));
        rows.push_back(tick(1'b0));
        // restart mid-sweep
        rows.push_back(tick_pt(1'b1, 0, 16384, 0, 0, 1'b0));
        rows.push_back(tick(1'b0));
        // count cut below the running index ends the sweep on the next point
        rows.push_back(cfg(lpg_pkg::REG_POINT_COUNT, 32'd1));
        rows.push_back(tick(1'b0));
        rows.push_back(tick(1'b0));
        // writes to unmapped registers must not disturb anything
        rows.push_back(cfg(3'd5, 32'hFFFF_FFFF));
        rows.push_back(cfg(3'd6, 32'hFFFF_FFFF));
        rows.push_back(cfg(3'd7, 32'hFFFF_FFFF));
        rows.push_back(cfg(lpg_pkg::REG_X_MULT, 32'd100));
        rows.push_back(cfg(lpg_pkg::REG_POINT_COUNT, 32'd1000));
        rows.push_back(cfg(lpg_pkg::REG_PHASE_STEP, 32'd167772));
        rows.push_back(tick_pt(1'b1, 0, 16384, 0, 0, 1'b0));
        rows.push_back(tick(1'b0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].reg_write)
            begin
                drain();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
                send_tick(rows[i].restart, rows[i].typed, rows[i].pt);
        end

        while (items_sent < TARGET_ITEMS)
        begin
            drain();
            steady = ($urandom_range(0, 4) == 0);
            write_reg(lpg_pkg::REG_X_MULT, pick_mult());
            write_reg(lpg_pkg::REG_Y_MULT, pick_mult());
            write_reg(lpg_pkg::REG_Z_MULT, pick_mult());

            v = $urandom();
            r = $urandom_range(0, 99);
            if (r < 75)
                v[9:0] = 10'($urandom_range(2, 40));
            else if (r < 85)
                v[9:0] = 10'($urandom_range(0, 1));
            else if (r < 95)
                v[9:0] = 10'($urandom_range(41, 1023));
            else
                v[9:0] = ($urandom_range(0, 1) != 0) ? 10'd1000 : 10'd1023;
            write_reg(lpg_pkg::REG_POINT_COUNT, v);

            v = $urandom();
            r = $urandom_range(0, 99);
            n = effective_count();
            if (r < 50)
                v[23:0] = 24'((longint'($urandom_range(1, 8)) << 24) / n);
            else if (r < 60)
                v[23:0] = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
            else if (r < 65)
                v[23:0] = QUARTER_TURN;
            write_reg(lpg_pkg::REG_PHASE_STEP, v);

            if ($urandom_range(0, 4) == 0)
                write_reg(3'($urandom_range(5, 7)), $urandom());

            n_items = ($urandom_range(0, 11) == 0) ? $urandom_range(500, 1010)
                                                   : $urandom_range(10, 120);
            if (n_items > TARGET_ITEMS - items_sent)
                n_items = TARGET_ITEMS - items_sent;
            for (int k = 0; k < n_items; k++)
            begin
                if (!sweep_on)
                    restart = ($urandom_range(0, 9) != 0);
                else
                    restart = ($urandom_range(0, 49) == 0);
                send_tick(restart, 1'b0, none);
            end
        end

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
